FILE: hdl/llsr_pkg.sv
package llsr_pkg;

    typedef logic [0:7][7:0] row_t;
    typedef logic [0:3][7:0] quad_t;

    // header and ID codes
    localparam logic [7:0] BREAK_BYTE = 8'h00;
    localparam logic [7:0] SYNC_BYTE  = 8'h55;
    localparam logic [7:0] ID_WR_LONG = 8'hF5;
    localparam logic [7:0] ID_WR_SHRT = 8'h11;
    localparam logic [7:0] ID_WR_MODE = 8'h92;
    localparam logic [7:0] ID_RD_LOCK = 8'hC1;
    localparam logic [7:0] ID_RD_SER  = 8'h32;
    localparam logic [7:0] ID_RD_KEY  = 8'h37;
    localparam logic [7:0] ID_RD_IDNT = 8'h61;
    localparam logic [7:0] ID_RD_STAT = 8'h7D;
    localparam logic [7:0] INSERT_TAG = 8'h55;

    // lock position sequence
    localparam logic [7:0] LOCK_HI_START = 8'h08;
    localparam logic [7:0] LOCK_LO_START = 8'h01;
    localparam logic [7:0] LOCK_LO_INS   = 8'h04;
    localparam logic [7:0] LOCK_LO_EXIT  = 8'h06;
    localparam logic [7:0] LOCK_INS_END  = 8'h16;
    localparam logic [7:0] LOCK_EXIT_END = 8'h12;
    localparam logic [7:0] LOCK_HI_INS   = 8'h07;
    localparam logic [7:0] LOCK_HI_EXIT  = 8'h04;

    localparam logic [3:0] LEN_LONG = 4'd8;
    localparam logic [3:0] LEN_SHRT = 4'd2;
    localparam logic [3:0] LEN_IDNT = 4'd4;

    localparam row_t KEY_ROWS [5] = '{
        '{8'h04, 8'h03, 8'hA4, 8'h46, 8'hE1, 8'hD6, 8'h62, 8'h00},
        '{8'h04, 8'h02, 8'hA4, 8'h46, 8'hE1, 8'hD6, 8'h62, 8'h00},
        '{8'h08, 8'h03, 8'h58, 8'hAD, 8'h54, 8'hF6, 8'h7C, 8'h00},
        '{8'h07, 8'h04, 8'h58, 8'hAD, 8'h54, 8'hF6, 8'h7C, 8'h00},
        '{8'h07, 8'h05, 8'h58, 8'hAD, 8'h54, 8'hF6, 8'h7C, 8'h00}};

    localparam row_t STATUS_INS  = '{8'h30, 8'h80, 8'h76, 8'h9A, 8'h9C, 8'hA6, 8'h00, 8'h00};
    localparam row_t STATUS_EXIT = '{8'hCF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam quad_t IDENT_ROW  = '{8'h87, 8'h0B, 8'h29, 8'h0C};

    localparam row_t SERIAL_ROWS [4] = '{
        '{8'h01, 8'h00, 8'h30, 8'h79, 8'h39, 8'h71, 8'h44, 8'h00},
        '{8'h02, 8'h36, 8'h47, 8'h39, 8'h4E, 8'h00, 8'h00, 8'h00},
        '{8'h03, 8'h33, 8'h46, 8'h38, 8'h38, 8'h30, 8'h00, 8'h00},
        '{8'h04, 8'h44, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}};

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic fill;
        logic load_data;
        logic load_sum;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic read_hit;
        logic last_data;
    } status_t;

    // one's complement add with end-around carry
    function automatic logic [7:0] sum_add(input logic [7:0] acc, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, acc} + {1'b0, b};
        return s[8] ? (s[7:0] + 8'd1) : s[7:0];
    endfunction

endpackage

FILE: hdl/llsr_if.sv
interface llsr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface llsr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       tx_last;

    modport source (output valid, output tx_byte, output tx_last, input ready);
    modport sink   (input valid, input tx_byte, input tx_last, output ready);
endinterface

FILE: hdl/llsr_dp.sv
module llsr_dp
    import llsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic [7:0] rx_byte,
    output status_t    status,
    output logic [7:0] tx_byte,
    output logic       tx_last
);

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_BREAK = 5'b00010,
        PH_SYNC  = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_SUM   = 5'b10000
    } rx_phase_t;

    typedef enum logic [4:0] {
        KP_NONE  = 5'b00001,
        KP_INS1  = 5'b00010,
        KP_INS2  = 5'b00100,
        KP_EXIT1 = 5'b01000,
        KP_EXIT2 = 5'b10000
    } key_phase_t;

    rx_phase_t  rx_phase_reg, rx_phase_next;
    key_phase_t key_phase_reg, key_phase_next;
    logic [7:0] frame_ident_reg, frame_ident_next;
    logic [3:0] rx_count_reg, rx_count_next;
    logic [3:0] rx_length_reg, rx_length_next;
    logic [7:0] rx_sum_reg, rx_sum_next;
    logic [7:0] first_data_reg, first_data_next;
    logic [7:0] lock_high_reg, lock_high_next;
    logic [7:0] lock_low_reg, lock_low_next;
    logic [1:0] serial_slot_reg, serial_slot_next;
    logic [1:0] key_slot_reg, key_slot_next;
    row_t       tx_store_reg, tx_store_next;

    logic [2:0] idx_reg, idx_next;
    logic [3:0] tx_len_reg, tx_len_next;
    logic [7:0] tx_sum_reg, tx_sum_next;
    logic [7:0] tx_byte_reg, tx_byte_next;
    logic       tx_last_reg, tx_last_next;

    logic [3:0] count_inc;
    logic [7:0] lo_inc;
    logic [1:0] k;
    logic       is_ins, is_exit;

    assign is_ins  = (key_phase_reg == KP_INS1) || (key_phase_reg == KP_INS2);
    assign is_exit = (key_phase_reg == KP_EXIT1) || (key_phase_reg == KP_EXIT2);

    assign status.read_hit = (rx_phase_reg == PH_SYNC) &&
        ((rx_byte == ID_RD_LOCK) || (rx_byte == ID_RD_SER) || (rx_byte == ID_RD_KEY) ||
         (rx_byte == ID_RD_IDNT) || (rx_byte == ID_RD_STAT));
    assign status.last_data = (({1'b0, idx_reg} + 4'd1) == tx_len_reg);

    assign tx_byte = tx_byte_reg;
    assign tx_last = tx_last_reg;

    always_comb
    begin
        rx_phase_next    = rx_phase_reg;
        key_phase_next   = key_phase_reg;
        frame_ident_next = frame_ident_reg;
        rx_count_next    = rx_count_reg;
        rx_length_next   = rx_length_reg;
        rx_sum_next      = rx_sum_reg;
        first_data_next  = first_data_reg;
        lock_high_next   = lock_high_reg;
        lock_low_next    = lock_low_reg;
        serial_slot_next = serial_slot_reg;
        key_slot_next    = key_slot_reg;
        tx_store_next    = tx_store_reg;
        idx_next         = idx_reg;
        tx_len_next      = tx_len_reg;
        tx_sum_next      = tx_sum_reg;
        tx_byte_next     = tx_byte_reg;
        tx_last_next     = tx_last_reg;
        count_inc        = rx_count_reg + 4'd1;
        lo_inc           = lock_low_reg + 8'd1;
        k                = 2'd0;

        // receiver
        if (cmd.accept)
        begin
            unique case (rx_phase_reg)
                PH_BREAK:
                begin
                    rx_phase_next = (rx_byte == SYNC_BYTE) ? PH_SYNC : PH_IDLE;
                end
                PH_SYNC:
                begin
                    frame_ident_next = rx_byte;
                    rx_count_next    = 4'd0;
                    rx_sum_next      = 8'd0;
                    rx_phase_next    = PH_IDLE;
                    if ((rx_byte == ID_WR_LONG) || (rx_byte == ID_WR_SHRT) ||
                        (rx_byte == ID_WR_MODE))
                    begin
                        rx_length_next = (rx_byte == ID_WR_LONG) ? LEN_LONG : LEN_SHRT;
                        rx_phase_next  = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (rx_count_reg == 4'd0)
                    begin
                        first_data_next = rx_byte;
                    end
                    rx_sum_next   = sum_add(rx_sum_reg, rx_byte);
                    rx_count_next = count_inc;
                    if (count_inc >= rx_length_reg)
                    begin
                        rx_phase_next = PH_SUM;
                    end
                end
                PH_SUM:
                begin
                    if ((rx_byte == ~rx_sum_reg) && (frame_ident_reg == ID_WR_MODE))
                    begin
                        serial_slot_next = 2'd0;
                        key_slot_next    = 2'd0;
                        key_phase_next   = (first_data_reg == INSERT_TAG) ? KP_INS1 : KP_EXIT1;
                    end
                    rx_phase_next = PH_IDLE;
                end
                default:
                begin
                    rx_phase_next = (rx_byte == BREAK_BYTE) ? PH_BREAK : PH_IDLE;
                end
            endcase
        end

        // response preparation for a read ID
        if (cmd.fill)
        begin
            idx_next    = 3'd0;
            tx_sum_next = 8'd0;
            tx_len_next = LEN_LONG;
            unique case (frame_ident_reg)
                ID_RD_LOCK:
                begin
                    tx_len_next = LEN_SHRT;
                    if ((key_phase_reg == KP_INS1) || (key_phase_reg == KP_EXIT1))
                    begin
                        lock_high_next = LOCK_HI_START;
                        lock_low_next  = LOCK_LO_START;
                        key_phase_next = (key_phase_reg == KP_INS1) ? KP_INS2 : KP_EXIT2;
                    end
                    else if (key_phase_reg == KP_INS2)
                    begin
                        if (lock_low_reg == LOCK_LO_START)
                        begin
                            lock_low_next = LOCK_LO_INS;
                        end
                        else
                        begin
                            lock_low_next = lo_inc;
                            if (lo_inc == LOCK_INS_END)
                            begin
                                lock_high_next = LOCK_HI_INS;
                            end
                        end
                    end
                    else if (key_phase_reg == KP_EXIT2)
                    begin
                        if (lock_low_reg == LOCK_LO_START)
                        begin
                            lock_low_next = LOCK_LO_EXIT;
                        end
                        else
                        begin
                            lock_low_next = lo_inc;
                            if (lo_inc == LOCK_EXIT_END)
                            begin
                                lock_high_next = LOCK_HI_EXIT;
                            end
                        end
                    end
                    tx_store_next[0] = lock_high_next;
                    tx_store_next[1] = lock_low_next;
                end
                ID_RD_SER:
                begin
                    tx_store_next    = SERIAL_ROWS[serial_slot_reg];
                    serial_slot_next = serial_slot_reg + 2'd1;
                end
                ID_RD_KEY:
                begin
                    if (is_ins)
                    begin
                        k             = (key_slot_reg < 2'd2) ? key_slot_reg : 2'd0;
                        tx_store_next = KEY_ROWS[k];
                        key_slot_next = (k == 2'd1) ? 2'd0 : k + 2'd1;
                    end
                    else if (is_exit)
                    begin
                        k             = (key_slot_reg < 2'd3) ? key_slot_reg : 2'd0;
                        tx_store_next = KEY_ROWS[3'd2 + {1'b0, k}];
                        key_slot_next = (k == 2'd2) ? 2'd0 : k + 2'd1;
                    end
                end
                ID_RD_IDNT:
                begin
                    tx_len_next = LEN_IDNT;
                    for (int i = 0; i < 4; i++)
                    begin
                        tx_store_next[i] = IDENT_ROW[i];
                    end
                end
                ID_RD_STAT:
                begin
                    if (is_ins)
                    begin
                        tx_store_next = STATUS_INS;
                    end
                    else if (is_exit)
                    begin
                        tx_store_next = STATUS_EXIT;
                    end
                end
                default:
                begin
                    tx_len_next = tx_len_reg;
                end
            endcase
        end

        // output word register
        if (cmd.load_data)
        begin
            tx_byte_next = tx_store_reg[idx_reg];
            tx_last_next = 1'b0;
            tx_sum_next  = sum_add(tx_sum_reg, tx_store_reg[idx_reg]);
            idx_next     = idx_reg + 3'd1;
        end
        else if (cmd.load_sum)
        begin
            tx_byte_next = ~tx_sum_reg;
            tx_last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_phase_reg    <= PH_IDLE;
            key_phase_reg   <= KP_NONE;
            frame_ident_reg <= 8'd0;
            rx_count_reg    <= 4'd0;
            rx_length_reg   <= 4'd0;
            rx_sum_reg      <= 8'd0;
            first_data_reg  <= 8'd0;
            lock_high_reg   <= 8'd0;
            lock_low_reg    <= 8'd0;
            serial_slot_reg <= 2'd0;
            key_slot_reg    <= 2'd0;
            tx_store_reg    <= '0;
        end
        else
        begin
            rx_phase_reg    <= rx_phase_next;
            key_phase_reg   <= key_phase_next;
            frame_ident_reg <= frame_ident_next;
            rx_count_reg    <= rx_count_next;
            rx_length_reg   <= rx_length_next;
            rx_sum_reg      <= rx_sum_next;
            first_data_reg  <= first_data_next;
            lock_high_reg   <= lock_high_next;
            lock_low_reg    <= lock_low_next;
            serial_slot_reg <= serial_slot_next;
            key_slot_reg    <= key_slot_next;
            tx_store_reg    <= tx_store_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        tx_len_reg  <= tx_len_next;
        tx_sum_reg  <= tx_sum_next;
        tx_byte_reg <= tx_byte_next;
        tx_last_reg <= tx_last_next;
    end

endmodule

FILE: hdl/llsr_ctrl.sv
module llsr_ctrl
    import llsr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    rx_valid,
    output logic    rx_ready,
    output logic    tx_valid,
    input  logic    tx_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FILL = 4'b0010,
        S_SEND = 4'b0100,
        S_CSUM = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   tx_valid_reg, tx_valid_next;
    logic   slot_free;

    assign slot_free = !tx_valid_reg || tx_ready;
    assign rx_ready  = (state_reg == S_IDLE);
    assign tx_valid  = tx_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.fill      = 1'b0;
        cmd.load_data = 1'b0;
        cmd.load_sum  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = rx_valid;
                if (rx_valid && status.read_hit)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                cmd.fill   = 1'b1;
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (slot_free)
                begin
                    cmd.load_data = 1'b1;
                    if (status.last_data)
                    begin
                        state_next = S_CSUM;
                    end
                end
            end
            S_CSUM:
            begin
                if (slot_free)
                begin
                    cmd.load_sum = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_data || cmd.load_sum)
        begin
            tx_valid_next = 1'b1;
        end
        else if (tx_ready)
        begin
            tx_valid_next = 1'b0;
        end
        else
        begin
            tx_valid_next = tx_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tx_valid_reg <= tx_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_fill_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |-> $past(cmd.accept && status.read_hit))
        else $error("fill without a read ID");
    a_csum_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CSUM) |-> tx_valid_reg)
        else $error("checksum pending with no data word out");
    a_busy_no_rx: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SEND) || (state_reg == S_FILL)) |-> !rx_ready)
        else $error("receive open during response");
    a_sum_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_sum |=> (state_reg == S_IDLE) && tx_valid_reg)
        else $error("checksum load did not close response");
`endif

endmodule

FILE: hdl/lin_lock_slave_responder.sv
// Channel | Dir | Word                 | Notes
// rx      | in  | rx_byte[7:0]         | bus bytes: break, sync, ID, data, checksum
// tx      | out | tx_byte[7:0],tx_last | response data bytes, tx_last on checksum
//
// Sequence: a non-read byte leaves the block ready for the next. A read ID is
//   accepted, the store is filled, then the response words (2, 4 or 8 data +
//   checksum) go out one per cycle while tx is ready; the output register sets the pace.
// Reset: rst_n async low; receiver idle, no key mode, slots and store zero.
// Stalls: rx is taken only while no response is being built or sent; a held
//   tx word stalls the sequencer, the final checksum may still wait in tx
//   while the next rx byte is taken.
module lin_lock_slave_responder
    import llsr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    llsr_in_if.sink   rx,
    llsr_out_if.source tx
);

    cmd_t    cmd;
    status_t status;

    // sequencer: accept, fill, word loads
    llsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .tx_valid (tx.valid),
        .tx_ready (tx.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // frame parser, key/lock state, transmit store, checksum, output word
    llsr_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rx_byte (rx.rx_byte),
        .status  (status),
        .tx_byte (tx.tx_byte),
        .tx_last (tx.tx_last)
    );

endmodule

FILE: test/lin_lock_slave_responder_test.sv
`timescale 1ns / 100ps

module lin_lock_slave_responder_test;
    import llsr_pkg::*;

    // Receiver parse state, mirrored from the block's behavior
    typedef enum logic [2:0] {
        RX_IDLE  = 3'd0,
        RX_BREAK = 3'd1,
        RX_SYNC  = 3'd2,
        RX_DATA  = 3'd3,
        RX_SUM   = 3'd4
    } hdr_state_t;

    // Key mode: first lock read of a mode seeds the lock position, then it runs
    typedef enum logic [2:0] {
        KEY_NONE       = 3'd0,
        KEY_INS_FIRST  = 3'd1,
        KEY_INS_RUN    = 3'd2,
        KEY_EXIT_FIRST = 3'd3,
        KEY_EXIT_RUN   = 3'd4
    } key_state_t;

    // one response word as it leaves the tx channel
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } tx_word_t;

    localparam logic [7:0] READ_IDS [5] = '{ID_RD_LOCK, ID_RD_SER, ID_RD_KEY,
                                            ID_RD_IDNT, ID_RD_STAT};

    logic clk = 1'b0;
    logic rst_n;

    llsr_in_if  rx_ch ();
    llsr_out_if tx_ch ();

    lin_lock_slave_responder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the responder state
    // ------------------------------------------------------------------
    hdr_state_t hdr_state;
    key_state_t key_state;
    logic [7:0] frame_id;
    logic [3:0] data_count;
    logic [3:0] data_len;
    logic [7:0] data_sum;
    logic [7:0] data_first;
    logic [7:0] lock_hi;
    logic [7:0] lock_lo;
    logic [1:0] serial_idx;
    logic [1:0] key_idx;
    logic [7:0] resp_store [8];

    // words the block still owes us, oldest first
    tx_word_t expected_tx [$];

    // run bookkeeping
    int  error_count   = 0;
    int  words_checked = 0;
    int  bytes_sent    = 0;
    int  reads_sent    = 0;
    int  mode_frames   = 0;

    // idle knobs, percent of cycles
    int  send_idle_pct = 8;
    int  recv_idle_pct = 63;
    int  hold_count    = 0;     // forced tx hold-off, counted down by the sink

    tx_word_t got_word;
    tx_word_t want_word;

    // Bus checksum add: 8-bit sum with end-around carry
    function automatic logic [7:0] ones_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

    function automatic bit in_insert();
        return key_state == KEY_INS_FIRST || key_state == KEY_INS_RUN;
    endfunction

    function automatic bit in_exit();
        return key_state == KEY_EXIT_FIRST || key_state == KEY_EXIT_RUN;
    endfunction

    // Read ID: refill the store as the block does, queue data + checksum.
    // Unknown IDs queue nothing.
    function automatic void answer_read(input logic [7:0] id);
        int         len;
        int         k;
        logic [7:0] acc;
        len = 0;
        case (id)
            ID_RD_LOCK: begin
                if (key_state == KEY_INS_FIRST || key_state == KEY_EXIT_FIRST) begin
                    lock_hi   = LOCK_HI_START;
                    lock_lo   = LOCK_LO_START;
                    key_state = (key_state == KEY_INS_FIRST) ? KEY_INS_RUN : KEY_EXIT_RUN;
                end else if (key_state == KEY_INS_RUN) begin
                    if (lock_lo == LOCK_LO_START)
                        lock_lo = LOCK_LO_INS;
                    else
                    begin
                        lock_lo = lock_lo + 8'd1;   // wraps at 256
                        if (lock_lo == LOCK_INS_END)
                            lock_hi = LOCK_HI_INS;
                    end
                end else if (key_state == KEY_EXIT_RUN) begin
                    if (lock_lo == LOCK_LO_START)
                        lock_lo = LOCK_LO_EXIT;
                    else
                    begin
                        lock_lo = lock_lo + 8'd1;
                        if (lock_lo == LOCK_EXIT_END)
                            lock_hi = LOCK_HI_EXIT;
                    end
                end
                resp_store[0] = lock_hi;
                resp_store[1] = lock_lo;
                len = LEN_SHRT;
            end
            ID_RD_SER: begin
                for (int i = 0; i < 8; i++)
                    resp_store[i] = SERIAL_ROWS[serial_idx][i];
                serial_idx = serial_idx + 2'd1;
                len = LEN_LONG;
            end
            ID_RD_KEY: begin
                // no mode: store goes out stale
                if (in_insert()) begin
                    k = (key_idx < 2) ? key_idx : 0;
                    for (int i = 0; i < 8; i++)
                        resp_store[i] = KEY_ROWS[k][i];
                    key_idx = (k + 1 >= 2) ? 2'd0 : 2'(k + 1);
                end else if (in_exit()) begin
                    k = (key_idx < 3) ? key_idx : 0;
                    for (int i = 0; i < 8; i++)
                        resp_store[i] = KEY_ROWS[2 + k][i];
                    key_idx = (k + 1 >= 3) ? 2'd0 : 2'(k + 1);
                end
                len = LEN_LONG;
            end
            ID_RD_IDNT: begin
                // only the low four store bytes change
                for (int i = 0; i < 4; i++)
                    resp_store[i] = IDENT_ROW[i];
                len = LEN_IDNT;
            end
            ID_RD_STAT: begin
                if (in_insert())
                    for (int i = 0; i < 8; i++)
                        resp_store[i] = STATUS_INS[i];
                else if (in_exit())
                    for (int i = 0; i < 8; i++)
                        resp_store[i] = STATUS_EXIT[i];
                len = LEN_LONG;
            end
            default: len = 0;
        endcase
        if (len != 0) begin
            acc = 8'h00;
            for (int i = 0; i < len; i++) begin
                acc = ones_add(acc, resp_store[i]);
                expected_tx.push_back('{data: resp_store[i], last: 1'b0});
            end
            expected_tx.push_back('{data: ~acc, last: 1'b1});
        end
    endfunction

    // Advance the shadow by one accepted bus byte
    function automatic void track_bus_byte(input logic [7:0] b);
        case (hdr_state)
            RX_BREAK: hdr_state = (b == SYNC_BYTE) ? RX_SYNC : RX_IDLE;
            RX_SYNC: begin
                frame_id   = b;
                data_count = 4'd0;
                data_sum   = 8'h00;
                hdr_state  = RX_IDLE;
                if (b == ID_WR_LONG || b == ID_WR_SHRT || b == ID_WR_MODE) begin
                    data_len  = (b == ID_WR_LONG) ? LEN_LONG : LEN_SHRT;
                    hdr_state = RX_DATA;
                end else
                    answer_read(b);
            end
            RX_DATA: begin
                if (data_count == 4'd0)
                    data_first = b;
                data_sum   = ones_add(data_sum, b);
                data_count = data_count + 4'd1;
                if (data_count >= data_len)
                    hdr_state = RX_SUM;
            end
            RX_SUM: begin
                // only a good mode frame has an effect
                if (b == ~data_sum && frame_id == ID_WR_MODE) begin
                    serial_idx = 2'd0;
                    key_idx    = 2'd0;
                    key_state  = (data_first == INSERT_TAG) ? KEY_INS_FIRST : KEY_EXIT_FIRST;
                end
                hdr_state = RX_IDLE;
            end
            default: hdr_state = (b == BREAK_BYTE) ? RX_BREAK : RX_IDLE;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: MISMATCH %s", $realtime, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // tx sink: random or forced hold-off, ready changes on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_count > 0) begin
            tx_ch.ready <= 1'b0;
            hold_count = hold_count - 1;
        end else
            tx_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // tx checker: each word against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && tx_ch.valid && tx_ch.ready) begin
            got_word = '{data: tx_ch.tx_byte, last: tx_ch.tx_last};
            if (expected_tx.size() == 0)
                report_mismatch($sformatf("unexpected word %02h last %b",
                                          got_word.data, got_word.last));
            else
            begin
                want_word = expected_tx.pop_front();
                if (got_word.data !== want_word.data)
                    report_mismatch($sformatf("tx_byte %02h, want %02h",
                                              got_word.data, want_word.data));
                if (got_word.last !== want_word.last)
                    report_mismatch($sformatf("tx_last %b, want %b on byte %02h",
                                              got_word.last, want_word.last, want_word.data));
                words_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one byte, idling first at random; returns right after the
    // accepting edge with valid still high, so back-to-back bytes never
    // drop valid within one step.
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        track_bus_byte(b);
        bytes_sent++;
    endtask

    // Drop valid and wait for every owed word, then the block's tail latency
    task automatic settle();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (expected_tx.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic send_header(input logic [7:0] id);
        send_byte(BREAK_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(id);
        if (id == ID_RD_LOCK || id == ID_RD_SER || id == ID_RD_KEY ||
            id == ID_RD_IDNT || id == ID_RD_STAT)
            reads_sent++;
    endtask

    // Write frame: first data byte given, rest random, checksum good or
    // with one bit flipped
    task automatic send_write(input logic [7:0] id, input logic [7:0] first,
                              input bit good);
        logic [7:0] acc;
        logic [7:0] b;
        int         len;
        len = (id == ID_WR_LONG) ? LEN_LONG : LEN_SHRT;
        acc = 8'h00;
        send_header(id);
        for (int i = 0; i < len; i++) begin
            b   = (i == 0) ? first : 8'($urandom_range(255));
            acc = ones_add(acc, b);
            send_byte(b);
        end
        send_byte(good ? ~acc : (~acc ^ (8'd1 << $urandom_range(7))));
        if (id == ID_WR_MODE)
            mode_frames++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // No mode yet: key and status reads send the stale store, lock read
    // sends zeros, ident read rewrites only the low four bytes
    task automatic test_stale_reads();
        send_header(ID_RD_KEY);
        send_header(ID_RD_LOCK);
        send_header(ID_RD_IDNT);
        send_header(ID_RD_STAT);
        send_header(ID_RD_SER);
    endtask

    // Bad sync, stray byte in idle, unknown IDs (zero and all ones)
    task automatic test_header_faults();
        send_byte(BREAK_BYTE);
        send_byte(8'hAA);
        send_byte(SYNC_BYTE);
        send_header(8'h00);
        send_header(8'hFF);
    endtask

    // Plain writes are swallowed; a mode frame with a bad checksum must
    // leave the block without a mode
    task automatic test_write_frames();
        send_write(ID_WR_SHRT, 8'hFF, 1'b1);
        send_write(ID_WR_LONG, 8'h00, 1'b1);
        send_write(ID_WR_MODE, INSERT_TAG, 1'b0);
        send_header(ID_RD_STAT);
        settle();
    endtask

    // Insert then exit mode: lock sequence past its end marks, key row
    // rotation, status rows, serial rotation and its reset on mode change
    task automatic test_key_modes();
        send_write(ID_WR_MODE, INSERT_TAG, 1'b1);
        for (int i = 0; i < 4; i++)
            send_header(ID_RD_KEY);
        send_header(ID_RD_STAT);
        for (int i = 0; i < 5; i++)
            send_header(ID_RD_SER);
        for (int i = 0; i < 24; i++)
            send_header(ID_RD_LOCK);
        send_write(ID_WR_MODE, 8'h00, 1'b1);
        for (int i = 0; i < 20; i++)
            send_header(ID_RD_LOCK);
        for (int i = 0; i < 4; i++)
            send_header(ID_RD_KEY);
        send_header(ID_RD_STAT);
        send_header(ID_RD_SER);
        settle();
    endtask

    // Fresh insert mode, then lock reads back to back at full rate
    task automatic test_lock_sweep();
        send_write(ID_WR_MODE, INSERT_TAG, 1'b1);
        for (int i = 0; i < 8; i++)
            send_header(ID_RD_LOCK);
        settle();
    endtask

    // Long tx hold-off while rx keeps offering: block must back up and
    // stall its input, then everything drains
    task automatic test_backpressure();
        hold_count = 300;
        for (int i = 0; i < 6; i++)
            send_header((i % 2 == 0) ? ID_RD_SER : ID_RD_KEY);
        settle();
    endtask

    // Mostly well-formed frames with random content, some broken frames
    // and line noise
    task automatic run_random(input int n_bytes);
        int         stop_at;
        int         pick;
        logic [7:0] id;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_header(READ_IDS[$urandom_range(4)]);
            else if (pick < 52)
                send_write($urandom_range(1) ? ID_WR_LONG : ID_WR_SHRT,
                           8'($urandom_range(255)), $urandom_range(99) < 85);
            else if (pick < 62)
                send_write(ID_WR_MODE,
                           $urandom_range(1) ? INSERT_TAG : 8'($urandom_range(255)),
                           $urandom_range(99) < 85);
            else if (pick < 70)
                send_header(8'($urandom_range(255)));   // usually unknown ID
            else if (pick < 78) begin
                // break with a wrong sync
                send_byte(BREAK_BYTE);
                id = 8'($urandom_range(255));
                send_byte((id == SYNC_BYTE) ? ~id : id);
            end else if (pick < 86) begin
                // truncated write, a new header cuts in as data
                send_header($urandom_range(1) ? ID_WR_LONG : ID_WR_MODE);
                send_byte(8'($urandom_range(255)));
                send_header(READ_IDS[$urandom_range(4)]);
            end else
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        tx_ch.ready   = 1'b0;

        hdr_state  = RX_IDLE;
        key_state  = KEY_NONE;
        frame_id   = 8'h00;
        data_count = 4'd0;
        data_len   = 4'd0;
        data_sum   = 8'h00;
        data_first = 8'h00;
        lock_hi    = 8'h00;
        lock_lo    = 8'h00;
        serial_idx = 2'd0;
        key_idx    = 2'd0;
        for (int i = 0; i < 8; i++)
            resp_store[i] = 8'h00;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender mostly busy, receiver mostly stalling
        send_idle_pct = 8;
        recv_idle_pct = 63;
        test_stale_reads();
        test_header_faults();
        test_write_frames();
        test_key_modes();
        run_random(60);

        // sender gappy, receiver mostly ready
        send_idle_pct = 63;
        recv_idle_pct = 8;
        run_random(40);
        test_backpressure();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_lock_sweep();
        run_random(20);

        settle();

        $display("Covered %0d bus bytes, %0d read headers, %0d mode frames; %0d words checked.",
                 bytes_sent, reads_sent, mode_frames, words_checked);
        $display("Idle mixes both ways and none, a long tx hold-off, lock end marks in both modes.");
        if (error_count == 0)
            $display("lin_lock_slave_responder_test: PASS");
        else
            $display("lin_lock_slave_responder_test: FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("Timed out with %0d words still owed.", expected_tx.size());
        $display("lin_lock_slave_responder_test: FAIL");
        $finish;
    end

endmodule
